// ===== hw/rtl/cpps_pkg.sv =====
`timescale 1ns / 1ps

package cpps_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int MAX_CONTACTS = 32;
  localparam int QUEUE_DEPTH  = 4;

  localparam int VT_W = $clog2(MAX_VERTICES + 1);
  localparam int VA_W = $clog2(MAX_VERTICES);
  localparam int CC_W = $clog2(MAX_CONTACTS + 1);
  localparam int CA_W = $clog2(MAX_CONTACTS);
  localparam int QP_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  // Multiplier operand, product and divider widths.
  localparam int MA_W   = 34;
  localparam int MB_W   = 38;
  localparam int ACC_W  = 41;
  localparam int DIV_W  = 41;
  localparam int FRAC_W = 32;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SETN  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic signed [ACC_W-1:0] PARALLEL_Q30 = 41'sd1073634450;
  localparam logic signed [ACC_W-1:0] STEEP_Q30    = 41'sd186401581;
  localparam logic signed [ACC_W-1:0] FLAT_LIMIT   = 41'sd66;
  localparam logic [7:0]              NEAR_SQ      = 8'd43;
  localparam logic signed [32:0]      NEAR_SPAN    = 33'sd6;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SETN  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_kind_t;

  typedef logic [2:0][31:0] pt_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [5:0]         contact_total;
    logic               has_point;
    logic               final_res;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t kind;
    pt_t       vec;
    pt_t       org;
  } cmd_t;

  typedef struct packed {
    logic                    go;
    logic signed [MA_W-1:0]  a;
    logic signed [MB_W-1:0]  b;
    logic                    sh31;
    logic                    first;
    logic                    sub;
    logic [1:0]              tag;
  } mac_req_t;

  typedef struct packed {
    logic                    pvalid;
    logic [1:0]              tag;
    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] acc;
  } mac_rsp_t;

  function automatic logic signed [32:0] sx33(input logic [31:0] v);
    return $signed({v[31], v});
  endfunction

  function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] v);
    return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
  endfunction

  function automatic logic [1:0] nxt3(input logic [1:0] k);
    return (k == 2'd2) ? 2'd0 : k + 2'd1;
  endfunction

  // Base plus or minus a wide delta, clamped to the 32-bit signed range.
  function automatic logic [31:0] sat_add(input logic [31:0] base,
                                          input logic signed [ACC_W-1:0] delta,
                                          input logic sub);
    logic signed [ACC_W:0] s;
    s = $signed({{(ACC_W-31){base[31]}}, base});
    s = sub ? s - (ACC_W+1)'(delta) : s + (ACC_W+1)'(delta);
    if (s > $signed((ACC_W+1)'(33'sd2147483647))) return 32'h7fffffff;
    if (s < $signed((ACC_W+1)'(-33'sd2147483648))) return 32'h80000000;
    return s[31:0];
  endfunction

  // Two points are near when every axis is within six and the squared
  // distance stays below the limit.
  function automatic logic near_pt(input pt_t a, input pt_t b);
    logic signed [32:0] d;
    logic [32:0]        ad;
    logic [7:0]         s;
    logic               ok;
    s  = 8'd0;
    ok = 1'b1;
    for (int k = 0; k < 3; k++) begin
      d  = sx33(a[k]) - sx33(b[k]);
      ad = d[32] ? 33'(-d) : 33'(d);
      if (d > NEAR_SPAN || d < -NEAR_SPAN) ok = 1'b0;
      s = s + 8'(ad[2:0] * ad[2:0]);
    end
    return ok && (s < NEAR_SQ);
  endfunction

endpackage

// ===== hw/rtl/convex_polygon_plane_section_unit.sv =====
`timescale 1ns / 1ps

// Convex polygon against plane contact unit.
//
// Input beats (item_valid / item_ready) carry one operation each: load a
// vertex, set the face normal and clear the polygon, or query a plane.
// Loads and normal writes give no result beat; a query gives one result beat
// per contact, the last marked by final_res, or a single empty beat with
// has_point low when there are no contacts.
// A front stage takes each beat into a four-entry command queue, and
// item_ready falls only while that queue is full. The back end retires a
// load or normal write straight from its idle state. A query first
// classifies the plane against the face normal. A nearly parallel one then
// copies the polygon vertex by vertex. Otherwise the walk primes on the last
// vertex, then takes each stored vertex in turn, projects those above a
// moderate plane and finds each edge crossing, where a 31-step divider gives
// the crossing fraction. A collapse to two extreme points adds a pass that
// ranks every contact along the line of the two planes. Results then leave
// one beat at a time. When the receiver stalls, the last result is held in
// the output register and the back end stops at its next result.
// Reset clears the polygon, face normal, queue and output valid flag.

module convex_polygon_plane_section_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  cpps_pkg::in_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output cpps_pkg::out_item_t  result
);

  logic           cmd_valid;
  logic           cmd_ready;
  cpps_pkg::cmd_t cmd;

  // Front end: accepts and classifies beats and queues them.
  cpps_front u_front (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  // Back end: polygon store, query sequencer and output register.
  cpps_back u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

endmodule

// ===== hw/rtl/cpps_front.sv =====
`timescale 1ns / 1ps

module cpps_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  cpps_pkg::in_item_t  item,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output cpps_pkg::cmd_t      cmd
);

  cpps_pkg::cmd_t                 q [cpps_pkg::QUEUE_DEPTH];
  logic [cpps_pkg::QP_W-1:0]      wr_ptr;
  logic [cpps_pkg::QP_W-1:0]      rd_ptr;
  logic [cpps_pkg::QC_W-1:0]      count;
  logic                           accept;
  logic                           keep;
  logic                           pop;
  cpps_pkg::cmd_t                 entry;

  assign item_ready = (count != cpps_pkg::QC_W'(cpps_pkg::QUEUE_DEPTH));
  assign accept     = item_valid && item_ready;
  assign cmd_valid  = (count != '0);
  assign cmd        = q[rd_ptr];
  assign pop        = cmd_valid && cmd_ready;

  // Unused operation codes are taken and dropped here.
  always_comb begin
    keep       = accept;
    entry.vec  = {item.vec_z, item.vec_y, item.vec_x};
    entry.org  = {item.origin_z, item.origin_y, item.origin_x};
    unique case (item.operation)
      cpps_pkg::OP_LOAD:  entry.kind = cpps_pkg::CMD_LOAD;
      cpps_pkg::OP_SETN:  entry.kind = cpps_pkg::CMD_SETN;
      cpps_pkg::OP_QUERY: entry.kind = cpps_pkg::CMD_QUERY;
      default: begin
        entry.kind = cpps_pkg::CMD_LOAD;
        keep       = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (keep) q[wr_ptr] <= entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (keep) begin
        wr_ptr <= (wr_ptr == cpps_pkg::QP_W'(cpps_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == cpps_pkg::QP_W'(cpps_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (keep && !pop) count <= count + 1'b1;
      else if (!keep && pop) count <= count - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/cpps_mac.sv =====
`timescale 1ns / 1ps

module cpps_mac (
  input  logic                clk,
  input  logic                rst,
  input  cpps_pkg::mac_req_t  req,
  output cpps_pkg::mac_rsp_t  rsp
);

  cpps_pkg::mac_req_t                        r1;
  logic [cpps_pkg::MA_W-1:0]                 ua;
  logic [cpps_pkg::MB_W-1:0]                 ub;
  logic [cpps_pkg::MA_W+cpps_pkg::MB_W-1:0]  full;
  logic [cpps_pkg::MA_W+cpps_pkg::MB_W-1:0]  shifted;
  logic signed [cpps_pkg::ACC_W-1:0]         prod_next;
  logic signed [cpps_pkg::ACC_W-1:0]         prod;
  logic signed [cpps_pkg::ACC_W-1:0]         acc;
  logic                                      v2;
  logic                                      first2;
  logic                                      sub2;
  logic [1:0]                                tag2;

  // Magnitude product, shifted right, then signed: truncation toward zero.
  always_comb begin
    ua        = r1.a[cpps_pkg::MA_W-1] ? cpps_pkg::MA_W'(-r1.a) : cpps_pkg::MA_W'(r1.a);
    ub        = r1.b[cpps_pkg::MB_W-1] ? cpps_pkg::MB_W'(-r1.b) : cpps_pkg::MB_W'(r1.b);
    full      = ua * ub;
    shifted   = r1.sh31 ? (full >> 31) : (full >> 30);
    prod_next = (r1.a[cpps_pkg::MA_W-1] ^ r1.b[cpps_pkg::MB_W-1])
              ? -$signed(cpps_pkg::ACC_W'(shifted)) : $signed(cpps_pkg::ACC_W'(shifted));
  end

  always_ff @(posedge clk) begin
    r1     <= req;
    prod   <= prod_next;
    first2 <= r1.first;
    sub2   <= r1.sub;
    tag2   <= r1.tag;
    if (v2) acc <= (first2 ? '0 : acc) + (sub2 ? -prod : prod);
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= r1.go;
  end

  assign rsp.pvalid = v2;
  assign rsp.tag    = tag2;
  assign rsp.prod   = prod;
  assign rsp.acc    = acc;

endmodule

// ===== hw/rtl/cpps_div.sv =====
`timescale 1ns / 1ps

module cpps_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [cpps_pkg::DIV_W-1:0]      num,
  input  logic [cpps_pkg::DIV_W-1:0]      den,
  output logic                            busy,
  output logic [cpps_pkg::FRAC_W-1:0]     quot
);

  logic [cpps_pkg::DIV_W-1:0] rem;
  logic [cpps_pkg::DIV_W-1:0] den_r;
  logic [cpps_pkg::DIV_W:0]   rs;
  logic [4:0]                 steps;

  assign rs = {rem, 1'b0};

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem   <= num;
      steps <= 5'(cpps_pkg::FRAC_W - 2);
      if (den == '0 || num >= den) quot <= cpps_pkg::FRAC_W'(1) << (cpps_pkg::FRAC_W - 1);
      else                         quot <= '0;
    end else if (busy) begin
      if (rs >= {1'b0, den_r}) begin
        rem  <= cpps_pkg::DIV_W'(rs - {1'b0, den_r});
        quot <= {quot[cpps_pkg::FRAC_W-2:0], 1'b1};
      end else begin
        rem  <= cpps_pkg::DIV_W'(rs);
        quot <= {quot[cpps_pkg::FRAC_W-2:0], 1'b0};
      end
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= !(den == '0 || num >= den);
    end else if (busy && steps == '0) begin
      busy <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/cpps_back.sv =====
`timescale 1ns / 1ps

module cpps_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  cpps_pkg::cmd_t       cmd,
  output logic                 result_valid,
  input  logic                 result_ready,
  output cpps_pkg::out_item_t  result
);

  typedef enum logic [25:0] {
    ST_IDLE     = 26'h0000001,
    ST_DOTF     = 26'h0000002,
    ST_CLASS    = 26'h0000004,
    ST_PAR_RD   = 26'h0000008,
    ST_PAR_WR   = 26'h0000010,
    ST_VRD      = 26'h0000020,
    ST_SIDE     = 26'h0000040,
    ST_SDONE    = 26'h0000080,
    ST_BODY     = 26'h0000100,
    ST_PROJ     = 26'h0000200,
    ST_DIV_GO   = 26'h0000400,
    ST_DIV_WAIT = 26'h0000800,
    ST_CROSS    = 26'h0001000,
    ST_PUSH     = 26'h0002000,
    ST_ADV      = 26'h0004000,
    ST_FIN      = 26'h0008000,
    ST_DIR      = 26'h0010000,
    ST_DIRCAP   = 26'h0020000,
    ST_CRD      = 26'h0040000,
    ST_CDOT     = 26'h0080000,
    ST_CCMP     = 26'h0100000,
    ST_CW0      = 26'h0200000,
    ST_CW1      = 26'h0400000,
    ST_NEAR     = 26'h0800000,
    ST_ER       = 26'h1000000,
    ST_EW       = 26'h2000000
  } state_t;

  state_t                              state;
  cpps_pkg::pt_t                       vmem [cpps_pkg::MAX_VERTICES];
  cpps_pkg::pt_t                       cmem [cpps_pkg::MAX_CONTACTS];
  cpps_pkg::pt_t                       vrd;
  cpps_pkg::pt_t                       crd;
  logic                                v_we, v_re, c_we, c_re;
  logic [cpps_pkg::VA_W-1:0]           v_waddr, v_raddr;
  logic [cpps_pkg::CA_W-1:0]           c_waddr, c_raddr;
  cpps_pkg::pt_t                       v_wdata, c_wdata;

  cpps_pkg::pt_t                       fn, org, p0, p1, pt, first_pt, last_pt, hi_pt, lo_pt;
  logic signed [32:0]                  n [3];
  logic signed [cpps_pkg::MB_W-1:0]    dir [3];
  logic signed [cpps_pkg::ACC_W-1:0]   s0, s1, maxd, hi, lo, dabs;
  logic [cpps_pkg::VT_W-1:0]           vtot, i;
  logic [cpps_pkg::CC_W-1:0]           cnt, j;
  logic [2:0]                          stp;
  logic [1:0]                          k, sel, k1, k2;
  logic                                moderate, prime, xpend, can_load;

  cpps_pkg::mac_req_t                  mreq;
  cpps_pkg::mac_rsp_t                  mrsp;
  logic                                div_start, div_busy;
  logic [cpps_pkg::FRAC_W-1:0]         frac;

  cpps_mac u_mac (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));

  cpps_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(cpps_pkg::mag(s0)), .den(cpps_pkg::mag(s1 - s0)),
    .busy(div_busy), .quot(frac)
  );

  assign cmd_ready = (state == ST_IDLE);
  assign sel       = (stp < 3'd3) ? stp[1:0] : 2'd0;
  assign k1        = cpps_pkg::nxt3(k);
  assign k2        = cpps_pkg::nxt3(k1);
  assign can_load  = !result_valid || result_ready;
  assign div_start = (state == ST_DIV_GO);
  assign dabs      = mrsp.acc[cpps_pkg::ACC_W-1] ? -mrsp.acc : mrsp.acc;

  // Operand issue for the shared multiplier.
  always_comb begin
    mreq       = '0;
    mreq.tag   = sel;
    mreq.first = (stp == 3'd0);
    unique case (state)
      ST_DOTF: begin
        mreq.go = (stp < 3'd3);
        mreq.a  = cpps_pkg::MA_W'($signed(fn[sel]));
        mreq.b  = cpps_pkg::MB_W'(n[sel]);
      end
      ST_SIDE: begin
        mreq.go = (stp < 3'd3);
        mreq.a  = cpps_pkg::MA_W'(n[sel]);
        mreq.b  = cpps_pkg::MB_W'(cpps_pkg::sx33(vrd[sel]) - cpps_pkg::sx33(org[sel]));
      end
      ST_PROJ: begin
        mreq.go = (stp < 3'd3);
        mreq.a  = cpps_pkg::MA_W'(n[sel]);
        mreq.b  = cpps_pkg::MB_W'(s0);
      end
      ST_CROSS: begin
        mreq.go   = (stp < 3'd3);
        mreq.a    = cpps_pkg::MA_W'(cpps_pkg::sx33(p1[sel]) - cpps_pkg::sx33(p0[sel]));
        mreq.b    = cpps_pkg::MB_W'($signed({1'b0, frac}));
        mreq.sh31 = 1'b1;
      end
      ST_DIR: begin
        mreq.go  = (stp < 3'd2);
        mreq.sub = (stp == 3'd1);
        mreq.a   = cpps_pkg::MA_W'($signed(fn[(stp == 3'd0) ? k1 : k2]));
        mreq.b   = cpps_pkg::MB_W'(n[(stp == 3'd0) ? k2 : k1]);
      end
      ST_CDOT: begin
        mreq.go = (stp < 3'd3);
        mreq.a  = cpps_pkg::MA_W'($signed(crd[sel]));
        mreq.b  = dir[sel];
      end
      default: mreq.go = 1'b0;
    endcase
  end

  // Memory port control.
  always_comb begin
    v_we    = (state == ST_IDLE) && cmd_valid && (cmd.kind == cpps_pkg::CMD_LOAD)
           && (vtot < cpps_pkg::VT_W'(cpps_pkg::MAX_VERTICES));
    v_waddr = vtot[cpps_pkg::VA_W-1:0];
    v_wdata = cmd.vec;
    v_re    = (state == ST_VRD) || (state == ST_PAR_RD);
    v_raddr = i[cpps_pkg::VA_W-1:0];
    c_re    = (state == ST_CRD) || (state == ST_ER);
    c_raddr = j[cpps_pkg::CA_W-1:0];
    c_we    = 1'b0;
    c_waddr = cnt[cpps_pkg::CA_W-1:0];
    c_wdata = pt;
    unique case (state)
      ST_PUSH: begin
        c_we = !(cnt != '0 && cpps_pkg::near_pt(pt, last_pt))
            && (cnt < cpps_pkg::CC_W'(cpps_pkg::MAX_CONTACTS));
      end
      ST_PAR_WR: begin
        c_we    = (cnt < cpps_pkg::CC_W'(cpps_pkg::MAX_CONTACTS));
        c_wdata = vrd;
      end
      ST_CW0: begin
        c_we    = 1'b1;
        c_waddr = '0;
        c_wdata = hi_pt;
      end
      ST_CW1: begin
        c_we    = 1'b1;
        c_waddr = cpps_pkg::CA_W'(1);
        c_wdata = lo_pt;
      end
      default: c_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (v_we) vmem[v_waddr] <= v_wdata;
    if (v_re) vrd <= vmem[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) cmem[c_waddr] <= c_wdata;
    if (c_re) crd <= cmem[c_raddr];
  end

  // Payload registers of the sequencer.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && cmd.kind == cpps_pkg::CMD_QUERY) begin
          for (int q = 0; q < 3; q++) n[q] <= cpps_pkg::sx33(cmd.vec[q]);
          org <= cmd.org;
          stp <= '0;
        end
      end
      ST_DOTF, ST_SIDE, ST_DIR, ST_CDOT: stp <= stp + 1'b1;
      ST_CLASS: begin
        if (mrsp.acc[cpps_pkg::ACC_W-1]) begin
          for (int q = 0; q < 3; q++) n[q] <= -n[q];
        end
        cnt  <= '0;
        j    <= '0;
        maxd <= '0;
        if (dabs <= cpps_pkg::PARALLEL_Q30) begin
          moderate <= (dabs > cpps_pkg::STEEP_Q30);
          i        <= vtot - 1'b1;
          prime    <= 1'b1;
        end else begin
          moderate <= 1'b0;
          i        <= '0;
        end
      end
      ST_PAR_WR: begin
        if (cnt < cpps_pkg::CC_W'(cpps_pkg::MAX_CONTACTS)) begin
          cnt     <= cnt + 1'b1;
          last_pt <= vrd;
          if (cnt == '0) first_pt <= vrd;
        end
        i <= i + 1'b1;
      end
      ST_VRD: stp <= '0;
      ST_SDONE: begin
        s1 <= mrsp.acc;
        p1 <= vrd;
        if (prime) begin
          s0    <= mrsp.acc;
          p0    <= vrd;
          prime <= 1'b0;
          i     <= '0;
        end
      end
      ST_BODY: begin
        stp   <= '0;
        xpend <= moderate && (s0 > 0) && (s1 <= 0);
        if (moderate && s0 > 0 && s0 > maxd) maxd <= s0;
      end
      ST_PROJ: begin
        stp <= stp + 1'b1;
        if (mrsp.pvalid) pt[mrsp.tag] <= cpps_pkg::sat_add(p0[mrsp.tag], mrsp.prod, 1'b1);
      end
      ST_CROSS: begin
        stp <= stp + 1'b1;
        if (mrsp.pvalid) pt[mrsp.tag] <= cpps_pkg::sat_add(p0[mrsp.tag], mrsp.prod, 1'b0);
      end
      ST_DIV_WAIT: stp <= '0;
      ST_PUSH: begin
        if (c_we) begin
          cnt     <= cnt + 1'b1;
          last_pt <= pt;
          if (cnt == '0) first_pt <= pt;
        end
        xpend <= 1'b0;
      end
      ST_ADV: begin
        p0 <= p1;
        s0 <= s1;
        i  <= i + 1'b1;
      end
      ST_FIN: begin
        k   <= '0;
        stp <= '0;
        j   <= '0;
      end
      ST_DIRCAP: begin
        dir[k] <= cpps_pkg::MB_W'(mrsp.acc);
        k      <= k + 1'b1;
        stp    <= '0;
      end
      ST_CRD: stp <= '0;
      ST_CCMP: begin
        if (j == '0) begin
          hi    <= mrsp.acc;
          lo    <= mrsp.acc;
          hi_pt <= crd;
          lo_pt <= crd;
        end else begin
          if (mrsp.acc > hi) begin
            hi    <= mrsp.acc;
            hi_pt <= crd;
          end
          if (mrsp.acc < lo) begin
            lo    <= mrsp.acc;
            lo_pt <= crd;
          end
        end
        j <= j + 1'b1;
      end
      ST_CW1: begin
        cnt      <= cpps_pkg::CC_W'(2);
        first_pt <= hi_pt;
        last_pt  <= lo_pt;
      end
      ST_NEAR: begin
        if (cpps_pkg::near_pt(last_pt, first_pt)) cnt <= cnt - 1'b1;
        j <= '0;
      end
      ST_EW: begin
        if (can_load) j <= j + 1'b1;
      end
      default: stp <= stp;
    endcase
  end

  // Face normal, polygon size and sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      vtot  <= '0;
      fn    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.kind)
              cpps_pkg::CMD_LOAD: begin
                if (v_we) vtot <= vtot + 1'b1;
              end
              cpps_pkg::CMD_SETN: begin
                fn   <= cmd.vec;
                vtot <= '0;
              end
              cpps_pkg::CMD_QUERY: state <= ST_DOTF;
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_DOTF:   if (stp == 3'd4) state <= ST_CLASS;
        ST_CLASS: begin
          if (vtot == '0)                     state <= ST_ER;
          else if (dabs > cpps_pkg::PARALLEL_Q30) state <= ST_PAR_RD;
          else                                state <= ST_VRD;
        end
        ST_PAR_RD: state <= ST_PAR_WR;
        ST_PAR_WR: state <= (i + 1'b1 == vtot) ? ST_FIN : ST_PAR_RD;
        ST_VRD:    state <= ST_SIDE;
        ST_SIDE:   if (stp == 3'd4) state <= ST_SDONE;
        ST_SDONE:  state <= prime ? ST_VRD : ST_BODY;
        ST_BODY: begin
          if (moderate && s0 > 0)                              state <= ST_PROJ;
          else if ((moderate && s1 > 0) || (!moderate && ((s0 < 0 && s1 > 0) ||
                   (s0 > 0 && s1 < 0))))                       state <= ST_DIV_GO;
          else                                                 state <= ST_ADV;
        end
        ST_PROJ:     if (stp == 3'd4) state <= ST_PUSH;
        ST_DIV_GO:   state <= ST_DIV_WAIT;
        ST_DIV_WAIT: if (!div_busy) state <= ST_CROSS;
        ST_CROSS:    if (stp == 3'd4) state <= ST_PUSH;
        ST_PUSH:     state <= xpend ? ST_DIV_GO : ST_ADV;
        ST_ADV:      state <= (i + 1'b1 == vtot) ? ST_FIN : ST_VRD;
        ST_FIN: begin
          if (cnt > cpps_pkg::CC_W'(1) && moderate && maxd < cpps_pkg::FLAT_LIMIT) begin
            state <= ST_DIR;
          end else if (cnt > cpps_pkg::CC_W'(1)) begin
            state <= ST_NEAR;
          end else begin
            state <= ST_ER;
          end
        end
        ST_DIR:    if (stp == 3'd3) state <= ST_DIRCAP;
        ST_DIRCAP: state <= (k == 2'd2) ? ST_CRD : ST_DIR;
        ST_CRD:    state <= ST_CDOT;
        ST_CDOT:   if (stp == 3'd4) state <= ST_CCMP;
        ST_CCMP:   state <= (j + 1'b1 == cnt) ? ST_CW0 : ST_CRD;
        ST_CW0:    state <= ST_CW1;
        ST_CW1:    state <= ST_NEAR;
        ST_NEAR:   state <= ST_ER;
        ST_ER:     state <= ST_EW;
        ST_EW: begin
          if (can_load) state <= (cnt == '0 || j + 1'b1 == cnt) ? ST_IDLE : ST_ER;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register: the next command runs while a result waits here.
  always_ff @(posedge clk) begin
    if (state == ST_EW && can_load) begin
      if (cnt == '0) begin
        result.point_x       <= '0;
        result.point_y       <= '0;
        result.point_z       <= '0;
        result.contact_total <= '0;
        result.has_point     <= 1'b0;
        result.final_res     <= 1'b1;
      end else begin
        result.point_x       <= $signed(crd[0]);
        result.point_y       <= $signed(crd[1]);
        result.point_z       <= $signed(crd[2]);
        result.contact_total <= 6'(cnt);
        result.has_point     <= 1'b1;
        result.final_res     <= (j + 1'b1 == cnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_EW && can_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/cpps_checker.sv =====
`timescale 1ns / 1ps

module cpps_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 result_valid,
  input logic                 result_ready,
  input cpps_pkg::out_item_t  result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result beat dropped while stalled");

  a_total: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !result.final_res |=>
      !result_valid || (result.contact_total == $past(result.contact_total)))
    else $error("contact total changed within one query");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.has_point |-> result.final_res && result.contact_total == 6'd0)
    else $error("empty answer not final or with a count");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind convex_polygon_plane_section_unit cpps_checker u_chk (.*);

// ===== tb/tb_convex_polygon_plane_section_unit.sv =====
`timescale 1ns / 1ps

// Contact predictor and result check for the polygon section unit.
class contact_board;
  logic signed [31:0] face_n [3];
  logic signed [31:0] vx [16];
  logic signed [31:0] vy [16];
  logic signed [31:0] vz [16];
  int unsigned vcount;
  cpps_pkg::out_item_t pending [$];
  int unsigned mismatches;

  function new();
    for (int k = 0; k < 3; k++) face_n[k] = 0;
    vcount = 0;
    mismatches = 0;
  endfunction

  static function longint mag64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Product truncated toward zero after a right shift of 30.
  static function longint mul30(longint a, longint b);
    logic [127:0] p;
    longint r;
    p = 128'(mag64(a)) * 128'(mag64(b));
    r = longint'(p >> 30);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  static function longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  static function bit close_pts(longint a [3], longint b [3]);
    longint d, s;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      d = a[k] - b[k];
      if (d > 6 || d < -6) return 0;
      s += d * d;
    end
    return s < 43;
  endfunction

  static function longint crossing_frac(longint num, longint den);
    longint q, r;
    q = 0;
    r = num;
    if (den == 0 || num >= den) return 64'sd1 << 31;
    for (int k = 0; k < 31; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    return q;
  endfunction

  local longint cx [$];
  local longint cy [$];
  local longint cz [$];

  local function void add_contact(longint p [3]);
    longint last [3];
    int n;
    n = cx.size();
    if (n > 0) begin
      last = '{cx[n-1], cy[n-1], cz[n-1]};
      if (close_pts(p, last)) return;
    end
    if (n >= 32) return;
    cx.push_back(p[0]);
    cy.push_back(p[1]);
    cz.push_back(p[2]);
  endfunction

  local function void add_crossing(longint p0 [3], longint p1 [3], longint s0, longint s1);
    longint f, dp, stp;
    longint pt [3];
    f = crossing_frac(mag64(s0), mag64(s1 - s0));
    for (int k = 0; k < 3; k++) begin
      dp = p1[k] - p0[k];
      stp = longint'((128'(mag64(dp)) * 128'(f)) >> 31);
      pt[k] = sat(dp < 0 ? p0[k] - stp : p0[k] + stp);
    end
    add_contact(pt);
  endfunction

  local function longint plane_side(longint n [3], longint o [3], longint p [3]);
    return mul30(n[0], p[0] - o[0]) + mul30(n[1], p[1] - o[1]) + mul30(n[2], p[2] - o[2]);
  endfunction

  // Notes one accepted input beat and queues the results it should cause.
  function void note_input(cpps_pkg::in_item_t it);
    longint n [3], o [3], p0 [3], p1 [3], pt [3], a [3], b [3], dir [3];
    longint dotf, s0, s1, maxd, pr, hi, lo;
    int ihi, ilo, cnt;
    bit moderate;
    cpps_pkg::out_item_t r;
    case (it.operation)
      cpps_pkg::OP_LOAD: begin
        if (vcount < 16) begin
          vx[vcount] = it.vec_x;
          vy[vcount] = it.vec_y;
          vz[vcount] = it.vec_z;
          vcount++;
        end
        return;
      end
      cpps_pkg::OP_SETN: begin
        face_n = '{it.vec_x, it.vec_y, it.vec_z};
        vcount = 0;
        return;
      end
      cpps_pkg::OP_QUERY: ;
      default: return;
    endcase
    n = '{longint'(it.vec_x), longint'(it.vec_y), longint'(it.vec_z)};
    o = '{longint'(it.origin_x), longint'(it.origin_y), longint'(it.origin_z)};
    cx.delete();
    cy.delete();
    cz.delete();
    moderate = 0;
    maxd = 0;
    dotf = mul30(face_n[0], n[0]) + mul30(face_n[1], n[1]) + mul30(face_n[2], n[2]);
    if (dotf < 0) begin
      for (int k = 0; k < 3; k++) n[k] = -n[k];
      dotf = -dotf;
    end
    if (vcount != 0) begin
      if (dotf > 1073634450) begin
        // Nearly parallel: the stored vertices come back as they are.
        for (int i = 0; i < vcount; i++) begin
          cx.push_back(vx[i]);
          cy.push_back(vy[i]);
          cz.push_back(vz[i]);
        end
      end else begin
        moderate = dotf > 186401581;
        p0 = '{vx[vcount-1], vy[vcount-1], vz[vcount-1]};
        s0 = plane_side(n, o, p0);
        for (int i = 0; i < vcount; i++) begin
          p1 = '{vx[i], vy[i], vz[i]};
          s1 = plane_side(n, o, p1);
          if (moderate) begin
            if (s0 > 0) begin
              if (s0 > maxd) maxd = s0;
              for (int k = 0; k < 3; k++) pt[k] = sat(p0[k] - mul30(n[k], s0));
              add_contact(pt);
              if (s1 <= 0) add_crossing(p0, p1, s0, s1);
            end else if (s1 > 0) begin
              add_crossing(p0, p1, s0, s1);
            end
          end else if ((s0 < 0 && s1 > 0) || (s0 > 0 && s1 < 0)) begin
            add_crossing(p0, p1, s0, s1);
          end
          s0 = s1;
          p0 = p1;
        end
      end
    end
    cnt = cx.size();
    if (cnt > 1) begin
      if (moderate && maxd < 66) begin
        // Shallow: keep only the two extremes along the line of the planes.
        dir[0] = mul30(face_n[1], n[2]) - mul30(face_n[2], n[1]);
        dir[1] = mul30(face_n[2], n[0]) - mul30(face_n[0], n[2]);
        dir[2] = mul30(face_n[0], n[1]) - mul30(face_n[1], n[0]);
        ihi = 0;
        ilo = 0;
        hi = 0;
        lo = 0;
        for (int i = 0; i < cnt; i++) begin
          pr = mul30(cx[i], dir[0]) + mul30(cy[i], dir[1]) + mul30(cz[i], dir[2]);
          if (i == 0) begin
            hi = pr;
            lo = pr;
          end else begin
            if (pr > hi) begin
              hi = pr;
              ihi = i;
            end
            if (pr < lo) begin
              lo = pr;
              ilo = i;
            end
          end
        end
        a = '{cx[ihi], cy[ihi], cz[ihi]};
        b = '{cx[ilo], cy[ilo], cz[ilo]};
        cx = '{a[0], b[0]};
        cy = '{a[1], b[1]};
        cz = '{a[2], b[2]};
        cnt = 2;
      end
      a = '{cx[cnt-1], cy[cnt-1], cz[cnt-1]};
      b = '{cx[0], cy[0], cz[0]};
      if (close_pts(a, b)) cnt--;
    end
    if (cnt == 0) begin
      r = '0;
      r.final_res = 1'b1;
      pending.push_back(r);
      return;
    end
    for (int i = 0; i < cnt; i++) begin
      r.point_x = cx[i][31:0];
      r.point_y = cy[i][31:0];
      r.point_z = cz[i][31:0];
      r.contact_total = 6'(cnt);
      r.has_point = 1'b1;
      r.final_res = (i == cnt - 1);
      pending.push_back(r);
    end
  endfunction

  function void check_result(cpps_pkg::out_item_t got);
    cpps_pkg::out_item_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat: %p", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("contact mismatch: expected %p, got %p", want, got);
    end
  endfunction
endclass

module tb_convex_polygon_plane_section_unit;

  // Random items after the directed part, which sends about forty.
  localparam int ITEM_COUNT = 220;
  // The run is abandoned when no beat moves in either direction beyond this limit.
  localparam int STALL_LIMIT = 20000;
  localparam logic signed [31:0] ONE_Q30 = 32'sh40000000;
  // The operation code that the block takes and ignores.
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  cpps_pkg::in_item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  cpps_pkg::out_item_t result;

  contact_board board;
  int idle_cycles = 0;
  bit quiet_phase;
  bit timed_out = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  convex_polygon_plane_section_unit DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  // Results are checked at the edge at which the beat is taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) board.check_result(result);
      if (item_valid && item_ready) board.note_input(item);
    end
  end

  // The receiver stalls at random with a chance of about six in a hundred, except
  // during the quiet phase, where it is always ready.
  always @(posedge clk) begin
    if (rst) result_ready <= 1'b0;
    else result_ready <= quiet_phase || ($urandom_range(99) >= 6);
  end

  // Watchdog on cycles in which no beat moves in either direction.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Presents one beat, with an occasional gap before it, and waits for it to
  // be taken. Valid stays high straight into the next beat when there is no gap.
  task automatic send_beat(input cpps_pkg::in_item_t it);
    if (!quiet_phase && $urandom_range(99) < 6) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic send_op(input logic [1:0] op, input logic signed [31:0] x, y, z,
                         input logic signed [31:0] ox = 0, oy = 0, oz = 0);
    cpps_pkg::in_item_t it;
    it.operation = op;
    it.vec_x = x;
    it.vec_y = y;
    it.vec_z = z;
    it.origin_x = ox;
    it.origin_y = oy;
    it.origin_z = oz;
    send_beat(it);
  endtask

  // Lets the block drain so that the next beat finds nothing outstanding.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] any_word();
    return $urandom();
  endfunction

  // A square with corners at plus and minus s, in the plane z = h, in loop order.
  task automatic load_square(input logic signed [31:0] s, input logic signed [31:0] h);
    send_op(cpps_pkg::OP_LOAD, -s, -s, h);
    send_op(cpps_pkg::OP_LOAD, s, -s, h);
    send_op(cpps_pkg::OP_LOAD, s, s, h);
    send_op(cpps_pkg::OP_LOAD, -s, s, h);
  endtask

  // A random convex polygon: points on a coarse circle near a z plane, with
  // a face normal that is either exact or slightly tilted.
  task automatic random_polygon(output int used);
    int nv, r;
    logic signed [31:0] h;
    real ang;
    nv = ($urandom_range(9) == 0) ? $urandom_range(3, 18) : $urandom_range(3, 7);
    r = $urandom_range(1, 200) * 65536;
    h = $urandom_range(0, 40) * 65536 - 20 * 65536;
    if ($urandom_range(3) == 0)
      send_op(cpps_pkg::OP_SETN, $signed($urandom_range(0, 2000)) - 1000, 0, ONE_Q30);
    else
      send_op(cpps_pkg::OP_SETN, 0, 0, $urandom_range(1) ? ONE_Q30 : -ONE_Q30);
    for (int i = 0; i < nv; i++) begin
      ang = 6.283185307 * i / nv;
      send_op(cpps_pkg::OP_LOAD, $rtoi(r * $cos(ang)), $rtoi(r * $sin(ang)),
              h + $signed($urandom_range(0, 4)) - 2);
    end
    used = 1 + nv;
  endtask

  // A query plane whose angle to the z axis falls in one of three bands, or anywhere up to a right angle.
  task automatic random_query();
    real tilt, az;
    logic signed [31:0] ox, oy, oz;
    case ($urandom_range(3))
      0: tilt = 0.001 * $urandom_range(0, 10);
      1: tilt = 0.2 + 0.01 * $urandom_range(0, 120);
      2: tilt = 1.40 + 0.001 * $urandom_range(0, 170);
      default: tilt = 0.001 * $urandom_range(0, 1570);
    endcase
    az = 0.0001 * $urandom_range(0, 62831);
    ox = $signed($urandom_range(0, 400 * 65536)) - 200 * 65536;
    oy = $signed($urandom_range(0, 400 * 65536)) - 200 * 65536;
    oz = $signed($urandom_range(0, 40 * 65536)) - 20 * 65536;
    send_op(cpps_pkg::OP_QUERY, $rtoi(1073741824.0 * $sin(tilt) * $cos(az)),
            $rtoi(1073741824.0 * $sin(tilt) * $sin(az)),
            $rtoi(1073741824.0 * $cos(tilt)) * ($urandom_range(1) ? 1 : -1), ox, oy, oz);
  endtask

  initial begin
    int sent, used;
    board = new();
    quiet_phase = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty polygon after reset, and the ignored operation code.
    send_op(cpps_pkg::OP_QUERY, 0, 0, ONE_Q30, 0, 0, 0);
    send_op(OP_SPARE, -1, -1, -1, -1, -1, -1);
    // Parallel plane returns the square as stored.
    send_op(cpps_pkg::OP_SETN, 0, 0, ONE_Q30);
    load_square(32'sd65536, 0);
    send_op(cpps_pkg::OP_QUERY, 0, 0, -ONE_Q30, 0, 0, 0);
    // Moderate tilt through the square, then one missing it (no contacts).
    send_op(cpps_pkg::OP_QUERY, 32'sd536870912, 0, 32'sd929887697, 0, 0, 0);
    send_op(cpps_pkg::OP_QUERY, 32'sd536870912, 0, 32'sd929887697, 0, 0, 32'sh7fffffff);
    // Steep plane: edge crossings only. Shallow tilt: projected vertices and crossings.
    send_op(cpps_pkg::OP_QUERY, ONE_Q30, 0, 0, 0, 0, 0);
    send_op(cpps_pkg::OP_QUERY, 32'sd200000000, 0, 32'sd1054000000, 0, 0, 32'sd3);
    // Extremes of every field, then a full store with loads beyond it.
    send_op(cpps_pkg::OP_SETN, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    load_square(32'sh7fffffff, 32'sh80000000);
    send_op(cpps_pkg::OP_QUERY, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
            32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    send_op(cpps_pkg::OP_SETN, 0, 0, 0);
    for (int i = 0; i < 18; i++) send_op(cpps_pkg::OP_LOAD, i * 3, 0, 32'sd5 * (i & 1));
    send_op(cpps_pkg::OP_QUERY, ONE_Q30, 0, 0, 32'sd20, 0, 0);

    // Sender hold-off until every expected result has come back.
    wait_drained();

    // Random part; the first stretch runs with no idling on either side.
    sent = 0;
    while (sent < ITEM_COUNT) begin
      quiet_phase = (sent < 40);
      if ($urandom_range(9) == 0) begin
        send_op(2'($urandom_range(3)), any_word(), any_word(), any_word(),
                any_word(), any_word(), any_word());
        sent++;
      end else begin
        random_polygon(used);
        sent += used;
        repeat ($urandom_range(1, 3)) begin
          random_query();
          sent++;
        end
      end
    end
    quiet_phase = 1'b0;

    wait_drained();
    repeat (200) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/cpps_pkg.sv
hw/rtl/cpps_front.sv
hw/rtl/cpps_mac.sv
hw/rtl/cpps_div.sv
hw/rtl/cpps_back.sv
hw/rtl/convex_polygon_plane_section_unit.sv
hw/rtl/cpps_checker.sv
tb/tb_convex_polygon_plane_section_unit.sv
